>>> hdl/mrs_pkg.sv
// Shared types and constants for the minimum refueling stops block.
// Used by mrs_ctrl, mrs_dp and min_refuel_stops_heap; depends on nothing.
package mrs_pkg;

  localparam int MAX_STATIONS_DEF = 1024;

  localparam int DATA_W  = 24;
  localparam int TANK_W  = 35;
  localparam int STOPS_W = 11;
  localparam int STAT_W  = 2;
  localparam int CFG_W   = 1;

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_INITIAL_FUEL = 1'b0;
  localparam logic [CFG_W-1:0] CFG_ROAD_LENGTH  = 1'b1;

  // trip status codes; ST_REACHED doubles as "no failure yet"
  localparam logic [STAT_W-1:0] ST_REACHED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNREACH  = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_ORDER    = 2'd3;

  // datapath commands
  typedef logic [4:0] op_t;
  localparam op_t OP_NONE       = 5'd0;
  localparam op_t OP_LOAD       = 5'd1;
  localparam op_t OP_ORDER_FAIL = 5'd2;
  localparam op_t OP_MOVE       = 5'd3;
  localparam op_t OP_UNREACH    = 5'd4;
  localparam op_t OP_POP_READ   = 5'd5;
  localparam op_t OP_POP_TAKE   = 5'd6;
  localparam op_t OP_POP_LAST   = 5'd7;
  localparam op_t OP_SIFT_END   = 5'd8;
  localparam op_t OP_SIFT_READ  = 5'd9;
  localparam op_t OP_SIFT_LATCH = 5'd10;
  localparam op_t OP_SIFT_RIGHT = 5'd11;
  localparam op_t OP_SIFT_DOWN  = 5'd12;
  localparam op_t OP_PUSH_INIT  = 5'd13;
  localparam op_t OP_PUSH_READ  = 5'd14;
  localparam op_t OP_PUSH_PLACE = 5'd15;
  localparam op_t OP_PUSH_UP    = 5'd16;
  localparam op_t OP_OVERFLOW   = 5'd17;
  localparam op_t OP_FINISH     = 5'd18;

  typedef struct packed {
    logic mode;          // latched item is a finish request
    logic fail_set;
    logic order_bad;     // target lies behind current position
    logic tank_ok;       // tank covers distance to target
    logic heap_empty;
    logic heap_full;
    logic sift_leaf;     // node being sifted has no children
    logic has_right;     // latched child has a right sibling
    logic cval_le_last;  // larger child does not beat the moved entry
    logic push_root;
    logic push_hold;     // parent already >= pushed value
    logic out_free;      // output register can take a result
  } dp_status_t;

endpackage

>>> hdl/mrs_dp.sv
// Datapath: config registers, trip state, heap RAM with its sift logic, output register.
// Depends on mrs_pkg; driven by op codes from mrs_ctrl.
module mrs_dp #(
  parameter int MAX_STATIONS = mrs_pkg::MAX_STATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrs_pkg::CFG_W-1:0]     cfg_index,
  input  logic [mrs_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          mode,
  input  logic [mrs_pkg::DATA_W-1:0]    station_pos,
  input  logic [mrs_pkg::DATA_W-1:0]    station_fuel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mrs_pkg::STOPS_W-1:0]   stop_count,
  output logic [mrs_pkg::STAT_W-1:0]    trip_status,
  input  mrs_pkg::op_t                  op,
  output mrs_pkg::dp_status_t           status
);
  import mrs_pkg::*;

  localparam int IW = $clog2(MAX_STATIONS);
  localparam int SW = $clog2(MAX_STATIONS + 1);
  localparam int CW = IW + 1;
  localparam logic [SW-1:0]      MAX_SIZE  = SW'(MAX_STATIONS);
  localparam logic [TANK_W-1:0]  TANK_MAX  = '1;
  localparam logic [STOPS_W-1:0] STOPS_MAX = '1;

  logic [DATA_W-1:0]  initial_fuel;
  logic [DATA_W-1:0]  road_length;
  logic [SW-1:0]      heap_size;
  logic [TANK_W-1:0]  tank_level;
  logic [DATA_W-1:0]  current_pos;
  logic [STOPS_W-1:0] stops_taken;
  logic [STAT_W-1:0]  fail_code;
  logic               trip_open;

  logic               item_mode;
  logic [DATA_W-1:0]  item_pos;
  logic [DATA_W-1:0]  item_fuel;
  logic [IW-1:0]      idx;
  logic [CW-1:0]      child;
  logic [DATA_W-1:0]  child_val;
  logic [DATA_W-1:0]  key_val;

  logic [DATA_W-1:0]  fuel_heap [MAX_STATIONS];
  logic [IW-1:0]      rd_addr;
  logic [DATA_W-1:0]  rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [DATA_W-1:0]  wr_data;

  logic [DATA_W-1:0]  target;
  logic [DATA_W-1:0]  leg_len;
  logic [TANK_W:0]    tank_sum;
  logic [TANK_W-1:0]  tank_add;
  logic [CW-1:0]      child_calc;
  logic [CW-1:0]      child_next;
  logic [CW-1:0]      size_ext;
  logic [SW-1:0]      size_less;
  logic [IW-1:0]      parent;

  assign cfg_ready  = 1'b1;

  assign target     = item_mode ? road_length : item_pos;
  assign leg_len    = target - current_pos;
  assign tank_sum   = {1'b0, tank_level} + (TANK_W + 1)'(rd_data);
  assign tank_add   = tank_sum[TANK_W] ? TANK_MAX : tank_sum[TANK_W-1:0];
  assign child_calc = {idx, 1'b1};
  assign child_next = child + 1'b1;
  assign size_ext   = CW'(heap_size);
  assign size_less  = heap_size - 1'b1;
  assign parent     = (idx - 1'b1) >> 1;

  always_comb begin
    status.mode         = item_mode;
    status.fail_set     = fail_code != ST_REACHED;
    status.order_bad    = target < current_pos;
    status.tank_ok      = tank_level >= TANK_W'(leg_len);
    status.heap_empty   = heap_size == '0;
    status.heap_full    = heap_size == MAX_SIZE;
    status.sift_leaf    = child_calc >= size_ext;
    status.has_right    = child_next < size_ext;
    status.cval_le_last = child_val <= key_val;
    status.push_root    = idx == '0;
    status.push_hold    = rd_data >= key_val;
    status.out_free     = !out_valid || !out_stall;
  end

  // one read and one write port on the heap RAM
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = key_val;
    case (op)
      OP_POP_TAKE:   rd_addr = size_less[IW-1:0];
      OP_SIFT_READ:  rd_addr = child_calc[IW-1:0];
      OP_SIFT_LATCH: rd_addr = child_next[IW-1:0];
      OP_PUSH_READ:  rd_addr = parent;
      OP_SIFT_END,
      OP_PUSH_PLACE: wr_en = 1'b1;
      OP_SIFT_DOWN: begin
        wr_en   = 1'b1;
        wr_data = child_val;
      end
      OP_PUSH_UP: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fuel_heap[wr_addr] <= wr_data;
    end
    rd_data <= fuel_heap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_fuel <= '0;
      road_length  <= '0;
      heap_size    <= '0;
      tank_level   <= '0;
      current_pos  <= '0;
      stops_taken  <= '0;
      fail_code    <= ST_REACHED;
      trip_open    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INITIAL_FUEL: initial_fuel <= cfg_data;
          CFG_ROAD_LENGTH:  road_length  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && op != OP_FINISH) begin
        out_valid <= 1'b0;
      end
      case (op)
        OP_LOAD: begin
          if (!trip_open) begin
            tank_level <= TANK_W'(initial_fuel);
            trip_open  <= 1'b1;
          end
        end
        OP_ORDER_FAIL: fail_code <= ST_ORDER;
        OP_UNREACH:    fail_code <= ST_UNREACH;
        OP_OVERFLOW:   fail_code <= ST_OVERFLOW;
        OP_MOVE: begin
          tank_level  <= tank_level - TANK_W'(leg_len);
          current_pos <= target;
        end
        OP_POP_TAKE: begin
          tank_level <= tank_add;
          heap_size  <= size_less;
          if (stops_taken != STOPS_MAX) begin
            stops_taken <= stops_taken + 1'b1;
          end
        end
        OP_PUSH_INIT: heap_size <= heap_size + 1'b1;
        OP_FINISH: begin
          out_valid   <= 1'b1;
          heap_size   <= '0;
          current_pos <= '0;
          stops_taken <= '0;
          fail_code   <= ST_REACHED;
          trip_open   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        item_mode <= mode;
        item_pos  <= station_pos;
        item_fuel <= station_fuel;
      end
      OP_POP_LAST: begin
        key_val <= rd_data;
        idx     <= '0;
      end
      OP_SIFT_READ:  child     <= child_calc;
      OP_SIFT_LATCH: child_val <= rd_data;
      OP_SIFT_RIGHT: begin
        if (rd_data > child_val) begin
          child     <= child_next;
          child_val <= rd_data;
        end
      end
      OP_SIFT_DOWN: idx <= child[IW-1:0];
      OP_PUSH_INIT: begin
        idx     <= heap_size[IW-1:0];
        key_val <= item_fuel;
      end
      OP_PUSH_UP: idx <= parent;
      OP_FINISH: begin
        if (fail_code == ST_REACHED) begin
          stop_count  <= stops_taken;
          trip_status <= ST_REACHED;
        end else begin
          stop_count  <= '0;
          trip_status <= fail_code;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    op == OP_POP_TAKE |-> heap_size != '0)
    else $error("fuel take from empty heap");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    op == OP_PUSH_INIT |-> heap_size != MAX_SIZE)
    else $error("push into full heap");

  a_move_legal: assert property (@(posedge clk) disable iff (rst)
    op == OP_MOVE |-> !status.order_bad && status.tank_ok)
    else $error("move without enough fuel or backwards");

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    op == OP_FINISH |-> !out_valid || !out_stall)
    else $error("result overwrites a pending one");

  a_finish_clear: assert property (@(posedge clk) disable iff (rst)
    op == OP_FINISH |=> out_valid && heap_size == '0 && !trip_open)
    else $error("trip not cleared after finish");
`endif

endmodule

>>> hdl/mrs_ctrl.sv
// Controller: sequences drive, fuel take (heap pop + sift down) and push (sift up).
// Depends on mrs_pkg; issues op codes to mrs_dp and reads its status.
module mrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mrs_pkg::dp_status_t status,
  output mrs_pkg::op_t        op
);
  import mrs_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_DRIVE    = 4'd2;
  localparam logic [3:0] S_POP1     = 4'd3;
  localparam logic [3:0] S_POP2     = 4'd4;
  localparam logic [3:0] S_SIFT_L   = 4'd5;
  localparam logic [3:0] S_SIFT_R   = 4'd6;
  localparam logic [3:0] S_SIFT_C   = 4'd7;
  localparam logic [3:0] S_SIFT_CMP = 4'd8;
  localparam logic [3:0] S_POST     = 4'd9;
  localparam logic [3:0] S_PUSH_L   = 4'd10;
  localparam logic [3:0] S_PUSH_C   = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // a failed trip skips stations and reports at finish
        if (status.fail_set) begin
          state_next = status.mode ? S_FIN : S_IDLE;
        end else begin
          state_next = S_DRIVE;
        end
      end
      S_DRIVE: begin
        if (status.order_bad) begin
          op         = OP_ORDER_FAIL;
          state_next = S_POST;
        end else if (status.tank_ok) begin
          op         = OP_MOVE;
          state_next = S_POST;
        end else if (status.heap_empty) begin
          op         = OP_UNREACH;
          state_next = S_POST;
        end else begin
          op         = OP_POP_READ;
          state_next = S_POP1;
        end
      end
      S_POP1: begin
        op         = OP_POP_TAKE;
        state_next = S_POP2;
      end
      S_POP2: begin
        op         = OP_POP_LAST;
        state_next = S_SIFT_L;
      end
      S_SIFT_L: begin
        if (status.sift_leaf) begin
          op         = OP_SIFT_END;
          state_next = S_DRIVE;
        end else begin
          op         = OP_SIFT_READ;
          state_next = S_SIFT_R;
        end
      end
      S_SIFT_R: begin
        op         = OP_SIFT_LATCH;
        state_next = status.has_right ? S_SIFT_C : S_SIFT_CMP;
      end
      S_SIFT_C: begin
        op         = OP_SIFT_RIGHT;
        state_next = S_SIFT_CMP;
      end
      S_SIFT_CMP: begin
        if (status.cval_le_last) begin
          op         = OP_SIFT_END;
          state_next = S_DRIVE;
        end else begin
          op         = OP_SIFT_DOWN;
          state_next = S_SIFT_L;
        end
      end
      S_POST: begin
        if (status.mode) begin
          state_next = S_FIN;
        end else if (status.fail_set) begin
          state_next = S_IDLE;
        end else if (status.heap_full) begin
          op         = OP_OVERFLOW;
          state_next = S_IDLE;
        end else begin
          op         = OP_PUSH_INIT;
          state_next = S_PUSH_L;
        end
      end
      S_PUSH_L: begin
        if (status.push_root) begin
          op         = OP_PUSH_PLACE;
          state_next = S_IDLE;
        end else begin
          op         = OP_PUSH_READ;
          state_next = S_PUSH_C;
        end
      end
      S_PUSH_C: begin
        if (status.push_hold) begin
          op         = OP_PUSH_PLACE;
          state_next = S_IDLE;
        end else begin
          op         = OP_PUSH_UP;
          state_next = S_PUSH_L;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          op         = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/min_refuel_stops_heap.sv
// Top level of the greedy minimum refueling stops engine.
// Depends on mrs_pkg, mrs_ctrl and mrs_dp.
//
// Stations are fed in order of position (mode 0), then a finish request
// (mode 1) drives to road_length and returns one result: the stop count and
// a status (reached, unreachable, heap overflow, order error). Each trip
// starts with initial_fuel; a failed trip ignores stations until finish.
// Passed fuel amounts live in a max-heap held in a single RAM with one read
// and one write per cycle, so one request at a time is worked on. A station
// request drives to its position, refuelling from the heap as needed (pop
// the root, sift the moved entry down), then pushes its fuel and sifts it up.
// A finish request drives to road_length with its refuels and waits for a
// free output register. The result sits in an output register, so the next
// request is taken while it waits. Config writes are taken every cycle and
// belong between trips or between requests.
module min_refuel_stops_heap #(
  parameter int MAX_STATIONS = mrs_pkg::MAX_STATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrs_pkg::CFG_W-1:0]     cfg_index,
  input  logic [mrs_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [mrs_pkg::DATA_W-1:0]    station_pos,
  input  logic [mrs_pkg::DATA_W-1:0]    station_fuel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mrs_pkg::STOPS_W-1:0]   stop_count,
  output logic [mrs_pkg::STAT_W-1:0]    trip_status
);
  import mrs_pkg::*;

  op_t        op;
  dp_status_t status;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  mrs_dp #(
    .MAX_STATIONS (MAX_STATIONS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .station_pos  (station_pos),
    .station_fuel (station_fuel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stop_count   (stop_count),
    .trip_status  (trip_status),
    .op           (op),
    .status       (status)
  );

endmodule

>>> tb/sv/min_refuel_stops_heap_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_refuel_stops_heap: directed trips, then random trips.
// Depends on mrs_pkg and the min_refuel_stops_heap RTL.
module min_refuel_stops_heap_test;
  import mrs_pkg::*;

  localparam bit MODE_STATION = 1'b0;
  localparam bit MODE_FINISH  = 1'b1;
  localparam int HEAP_DEPTH   = MAX_STATIONS_DEF;
  localparam int FILL_COUNT   = 160;
  localparam bit [DATA_W-1:0] DATA_MAX = '1;
  localparam longint unsigned TANK_MAX = (64'd1 << TANK_W) - 1;
  localparam int STALL_LIMIT = 200000;

  typedef struct packed {
    logic [STOPS_W-1:0] stops;
    logic [STAT_W-1:0]  status;
  } trip_result_t;

  // Tracks one trip at a time and queues the report each finish request owes.
  class trip_scoreboard;
    bit [DATA_W-1:0]  init_fuel;
    bit [DATA_W-1:0]  road_len;
    bit [DATA_W-1:0]  fuel_pool[$];
    longint unsigned  tank;
    bit [DATA_W-1:0]  here;
    bit [STOPS_W-1:0] stops;
    bit [STAT_W-1:0]  fail;
    bit               trip_open;
    trip_result_t     pending[$];
    int               errors;

    function void note_config(logic [CFG_W-1:0] idx, bit [DATA_W-1:0] val);
      if (idx == CFG_INITIAL_FUEL) init_fuel = val;
      else if (idx == CFG_ROAD_LENGTH) road_len = val;
    endfunction

    // greedy: burn the biggest fuel passed so far until the leg is covered
    function void travel_to(bit [DATA_W-1:0] target);
      int best;
      if (target < here) begin
        fail = ST_ORDER;
        return;
      end
      while (tank < longint'(target - here)) begin
        if (fuel_pool.size() == 0) begin
          fail = ST_UNREACH;
          return;
        end
        best = 0;
        foreach (fuel_pool[i]) if (fuel_pool[i] > fuel_pool[best]) best = i;
        tank += fuel_pool[best];
        fuel_pool.delete(best);
        if (tank > TANK_MAX) tank = TANK_MAX;
        if (stops != '1) stops++;
      end
      tank -= longint'(target - here);
      here = target;
    endfunction

    // returns 0 when the request is a station dropped by a failed trip
    function bit note_request(bit m, bit [DATA_W-1:0] pos, bit [DATA_W-1:0] fuel);
      trip_result_t res;
      if (!trip_open) begin
        tank = init_fuel;
        trip_open = 1'b1;
      end
      if (m == MODE_STATION) begin
        if (fail != ST_REACHED) return 1'b0;
        travel_to(pos);
        if (fail != ST_REACHED) return 1'b1;
        if (fuel_pool.size() >= HEAP_DEPTH) fail = ST_OVERFLOW;
        else fuel_pool.push_back(fuel);
        return 1'b1;
      end
      if (fail == ST_REACHED) travel_to(road_len);
      res.stops  = (fail == ST_REACHED) ? stops : '0;
      res.status = fail;
      pending.push_back(res);
      fuel_pool.delete();
      here = '0;
      stops = '0;
      fail = ST_REACHED;
      trip_open = 1'b0;
      return 1'b1;
    endfunction

    function void check_result(logic [STOPS_W-1:0] cnt, logic [STAT_W-1:0] st);
      trip_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result stop_count=%0d trip_status=%0d", $time, cnt, st);
        return;
      end
      want = pending.pop_front();
      if (cnt !== want.stops || st !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch stop_count exp %0d got %0d, trip_status exp %0d got %0d",
                   $time, want.stops, cnt, want.status, st);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_index = CFG_INITIAL_FUEL;
  logic [DATA_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = MODE_STATION;
  logic [DATA_W-1:0]  station_pos = '0;
  logic [DATA_W-1:0]  station_fuel = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [STOPS_W-1:0] stop_count;
  logic [STAT_W-1:0]  trip_status;

  trip_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int live_items = 0;

  wire any_fire = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready);

  min_refuel_stops_heap uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .station_pos(station_pos), .station_fuel(station_fuel),
    .out_valid(out_valid), .out_stall(out_stall),
    .stop_count(stop_count), .trip_status(trip_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(stop_count, trip_status);
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if (any_fire) idle_run = 0;
      else idle_run++;
    end
    $display("min_refuel_stops_heap_test NOT OK");
    $finish;
  end

  // all driving tasks start and end at a falling edge
  task automatic send_request(input bit m, input bit [DATA_W-1:0] pos,
                              input bit [DATA_W-1:0] fuel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    station_pos  <= pos;
    station_fuel <= fuel;
    do @(posedge clk); while (in_stall);
    if (sb.note_request(m, pos, fuel)) live_items++;
    @(negedge clk);
  endtask

  task automatic finish_trip();
    send_request(MODE_FINISH, DATA_W'($urandom), DATA_W'($urandom));
  endtask

  // hold off new requests until every report is back, then let the engine settle
  task automatic pause_for_results(input int settle);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_config(input bit [DATA_W-1:0] fuel, input bit [DATA_W-1:0] road);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INITIAL_FUEL;
    cfg_data  <= fuel;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(CFG_INITIAL_FUEL, fuel);
    @(negedge clk);
    cfg_index <= CFG_ROAD_LENGTH;
    cfg_data  <= road;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(CFG_ROAD_LENGTH, road);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    int unsigned road, fuel;
    road = $urandom & ((32'd1 << $urandom_range(1, DATA_W)) - 1);
    case ($urandom_range(7))
      0:       fuel = 0;
      1:       fuel = DATA_MAX;
      default: fuel = $urandom_range(0, road / 3);
    endcase
    write_config(DATA_W'(fuel), DATA_W'(road));
  endtask

  // mostly well-formed trips spread over the road; some go backwards,
  // overshoot the destination, or are plain noise
  task automatic random_trip();
    int n, kind, back_at;
    int unsigned road, step, p, prev, f;
    road = 32'(sb.road_len);
    kind = $urandom_range(9);
    n = ($urandom_range(7) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    step = road / (n + 1);
    back_at = (kind == 0) ? $urandom_range(0, n) : -1;
    p = 0;
    for (int i = 0; i < n; i++) begin
      prev = p;
      p += $urandom_range(0, 2 * step);
      if (p > road) p = road;
      if (kind == 2 && i == n - 1 && road < DATA_MAX) p = road + 1;
      f = $urandom_range(0, 3 * step + 3);
      if (f > DATA_MAX) f = DATA_MAX;
      if (kind == 1)
        send_request($urandom_range(7) == 0, DATA_W'($urandom), DATA_W'($urandom));
      else if (i == back_at && prev > 0)
        send_request(MODE_STATION, DATA_W'($urandom_range(0, prev - 1)), DATA_W'(f));
      else
        send_request(MODE_STATION, DATA_W'(p), DATA_W'(f));
    end
    finish_trip();
  endtask

  initial begin
    int goal;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct  = 37;
    recv_stall_pct = 68;

    // registers still at reset values
    finish_trip();
    pause_for_results(4);
    write_config(24'd10, 24'd100);
    send_request(MODE_STATION, 24'd10, 24'd60);
    send_request(MODE_STATION, 24'd20, 24'd30);
    send_request(MODE_STATION, 24'd30, 24'd30);
    send_request(MODE_STATION, 24'd60, 24'd40);
    finish_trip();
    // empty heap before the first station; next one is dropped
    send_request(MODE_STATION, 24'd20, 24'd5);
    send_request(MODE_STATION, 24'd30, 24'd100);
    finish_trip();
    // station behind the truck
    send_request(MODE_STATION, 24'd10, 24'd50);
    send_request(MODE_STATION, 24'd5, 24'd1);
    finish_trip();
    // destination behind the last station
    send_request(MODE_STATION, 24'd0, 24'd500);
    send_request(MODE_STATION, 24'd150, 24'd0);
    finish_trip();
    // registers rewritten mid-trip: new road applies now, new fuel next trip
    send_request(MODE_STATION, 24'd0, 24'd0);
    pause_for_results(300);
    write_config(24'd0, DATA_MAX);
    send_request(MODE_STATION, 24'd5, DATA_MAX);
    finish_trip();
    send_request(MODE_STATION, 24'd0, DATA_MAX);
    send_request(MODE_STATION, DATA_MAX, 24'd0);
    finish_trip();
    pause_for_results(4);
    write_config(DATA_MAX, 24'd0);
    finish_trip();
    pause_for_results(4);
    // zero-fuel pop, then stranded short of the destination
    write_config(24'd0, 24'd50);
    send_request(MODE_STATION, 24'd0, 24'd20);
    send_request(MODE_STATION, 24'd10, 24'd0);
    finish_trip();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 68 : 0;
      recv_stall_pct = (ph == 0) ? 68 : (ph == 1) ? 37 : 0;
      if (ph == 2) begin
        // deep heap built at one spot, then drained by the finish
        pause_for_results(4);
        write_config(24'd0, DATA_W'(FILL_COUNT * 128));
        for (int i = 0; i < FILL_COUNT; i++)
          send_request(MODE_STATION, 24'd0, DATA_W'($urandom_range(0, 255)));
        finish_trip();
      end
      goal = live_items + 100;
      while (live_items < goal) begin
        if ($urandom_range(3) == 0) begin
          pause_for_results(4);
          random_config();
        end
        random_trip();
      end
    end

    pause_for_results(1);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("min_refuel_stops_heap_test OK");
    end else begin
      $display("min_refuel_stops_heap_test NOT OK");
    end
    $finish;
  end

endmodule
